// ----- design/dmf_pkg.sv -----
// Shared types and constants for the dipole magnetic field evaluator.
package dmf_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_X = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_Y = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_X = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_Y = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENT_Z = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MOMENT   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RAD  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RAD  = 4'd7;

    localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
    localparam logic [47:0] FIELD_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FIELD_NEG_LIM = 48'h8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] dipole_x;
        logic signed [31:0] dipole_y;
        logic signed [31:0] orient_x;
        logic signed [31:0] orient_y;
        logic signed [31:0] orient_z;
        logic signed [63:0] moment;
        logic [30:0]        min_radius;
        logic [30:0]        max_radius;
    } cfg_t;

    // normalized request handed from front to back
    typedef struct packed {
        logic [2:0][29:0] e_mag;
        logic [2:0]       e_neg;
        logic [6:0]       k;
        logic             in_range;
        logic             zero;
    } task_t;

endpackage

// ----- design/dmf_ifs.sv -----
// Handshake channel interfaces: position requests, field results, register writes.
interface dmf_pos_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface dmf_field_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic               in_range;
    modport source (output valid, field_x, field_y, field_z, in_range, input ready);
    modport sink (input valid, field_x, field_y, field_z, in_range, output ready);
endinterface

interface dmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] wdata;
    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

// ----- design/dmf_front.sv -----
// Front end: takes positions, forms offset vector, range flag and normalization.
module dmf_front (
    input  logic          clk,
    input  logic          rst_n,
    dmf_pos_if.sink       pos,
    input  dmf_pkg::cfg_t cfg,
    output dmf_pkg::task_t push_data,
    output logic          push_valid,
    input  logic          push_ready
);
    import dmf_pkg::*;

    logic              a_valid_reg;
    logic [2:0][31:0]  dmag_reg;
    logic [2:0]        dneg_reg;
    logic [2:0][62:0]  sq_reg;
    logic [61:0]       mn2_reg;
    logic [61:0]       mx2_reg;

    logic signed [32:0] d [3];
    logic [31:0]        pmag [3];
    logic               take;

    assign take = pos.valid && pos.ready;
    assign pos.ready = !a_valid_reg || push_ready;

    always_comb
    begin
        d[0] = $signed({pos.pos_x[31], pos.pos_x}) - $signed({cfg.dipole_x[31], cfg.dipole_x});
        d[1] = $signed({pos.pos_y[31], pos.pos_y}) - $signed({cfg.dipole_y[31], cfg.dipole_y});
        d[2] = $signed({pos.pos_z[31], pos.pos_z});
        pmag[0] = pos.pos_x[31] ? 32'(-pos.pos_x) : 32'(pos.pos_x);
        pmag[1] = pos.pos_y[31] ? 32'(-pos.pos_y) : 32'(pos.pos_y);
        pmag[2] = pos.pos_z[31] ? 32'(-pos.pos_z) : 32'(pos.pos_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pos.ready)
        begin
            a_valid_reg <= pos.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dneg_reg[i] <= d[i][32];
                dmag_reg[i] <= d[i][32] ? 32'(-d[i]) : 32'(d[i]);
                sq_reg[i]   <= 63'(pmag[i]) * 63'(pmag[i]);
            end
            mn2_reg <= 62'(cfg.min_radius) * 62'(cfg.min_radius);
            mx2_reg <= 62'(cfg.max_radius) * 62'(cfg.max_radius);
        end
    end

    // normalization: largest component moved into [2^29, 2^30)
    logic [63:0] rr;
    logic [31:0] m;
    logic [1:0]  rs;
    logic [4:0]  top;
    logic [4:0]  ls;
    logic [63:0] sh;

    always_comb
    begin
        rr = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
        m = dmag_reg[0];
        if (dmag_reg[1] > m) m = dmag_reg[1];
        if (dmag_reg[2] > m) m = dmag_reg[2];
        top = 5'd0;
        for (int i = 0; i < 30; i++)
        begin
            if (m[i]) top = 5'(i);
        end
        if (m[31]) rs = 2'd2;
        else if (m[30]) rs = 2'd1;
        else rs = 2'd0;
        ls = (rs != 2'd0) ? 5'd0 : 5'(29 - int'(top));
        push_data.zero     = (m == 32'd0);
        push_data.in_range = (rr > 64'(mn2_reg)) && (rr < 64'(mx2_reg));
        push_data.k        = 7'(10 + 3 * int'(ls) - 3 * int'(rs));
        push_data.e_neg    = dneg_reg;
        for (int i = 0; i < 3; i++)
        begin
            sh = (64'(dmag_reg[i]) >> rs) << ls;
            push_data.e_mag[i] = sh[29:0];
        end
    end

    assign push_valid = a_valid_reg;

endmodule

// ----- design/dmf_fifo.sv -----
// Small request queue between front and back ends.
module dmf_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dmf_pkg::task_t wr_data,
    input  logic           wr_valid,
    output logic           wr_ready,
    output dmf_pkg::task_t rd_data,
    output logic           rd_valid,
    input  logic           rd_ready
);
    import dmf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    task_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wp_reg;
    logic [PTR_W-1:0]  rp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_wr && do_rd)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ----- design/dmf_back.sv -----
// Back end: sqrt, unit vector, dot product, moment scaling and field division.
module dmf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  dmf_pkg::cfg_t  cfg,
    input  dmf_pkg::task_t rd_data,
    input  logic           rd_valid,
    output logic           rd_ready,
    dmf_field_if.source    field
);
    import dmf_pkg::*;

    localparam logic [5:0] SQRT_LAST = 6'd30;
    localparam logic [5:0] DIV_LAST  = 6'd30;
    localparam logic [5:0] MUL_LAST  = 6'd4;
    localparam logic [5:0] QDIV_LAST = 6'd47;

    typedef enum logic [3:0] {
        S_IDLE, S_SUMSQ, S_SQRT, S_DIV, S_DOT1, S_DOT2,
        S_F1, S_F2, S_MUL, S_SHIFT, S_QDIV, S_FIN
    } state_t;

    state_t              state_reg;
    logic [5:0]          cnt_reg;
    logic [29:0]         e_mag_reg [3];
    logic [2:0]          e_neg_reg;
    logic [6:0]          k_reg;
    logic                rng_reg;
    logic                zero_reg;
    logic [61:0]         x_reg;
    logic [33:0]         rem_reg;
    logic [30:0]         root_reg;
    logic [30:0]         r_reg [3];
    logic [30:0]         nb_reg [3];
    logic [30:0]         q_reg [3];
    logic signed [63:0]  prod_reg [3];
    logic [61:0]         rn2_reg;
    logic signed [35:0]  dot_reg;
    logic signed [67:0]  fp_reg [3];
    logic [2:0]          fneg_reg;
    logic [39:0]         fmag_reg [3];
    logic [103:0]        nacc_reg [3];
    logic [101:0]        dacc_reg;
    logic [39:0]         rnsh_reg;
    logic [47:0]         xlo_reg [3];
    logic [2:0]          sat_reg;
    logic [92:0]         qr_reg [3];
    logic [47:0]         qq_reg [3];
    logic                out_valid_reg;
    logic signed [47:0]  fx_reg, fy_reg, fz_reg;
    logic                out_rng_reg;

    logic signed [31:0]  o [3];
    logic                mneg;
    logic [63:0]         mmag;
    logic [33:0]         rem2;
    logic [33:0]         trial;
    logic signed [31:0]  u [3];
    logic [31:0]         dt [3];
    logic signed [65:0]  s;
    logic signed [65:0]  s_adj;
    logic signed [67:0]  fp_adj [3];
    logic signed [40:0]  fv [3];
    logic [200:0]        wide [3];
    logic [93:0]         qt [3];
    logic [92:0]         dcube;
    logic [47:0]         res [3];
    logic                out_free;

    assign o[0]  = cfg.orient_x;
    assign o[1]  = cfg.orient_y;
    assign o[2]  = cfg.orient_z;
    assign mneg  = cfg.moment[63];
    assign mmag  = mneg ? 64'(-cfg.moment) : 64'(cfg.moment);
    assign dcube = dacc_reg[92:0];
    assign out_free = !out_valid_reg || field.ready;
    assign rd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        rem2  = {rem_reg[31:0], x_reg[61:60]};
        trial = {1'b0, root_reg, 2'b01};
        s = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]);
        s_adj = s[65] ? s + 66'(ONE_Q30 - 32'd1) : s;
        for (int i = 0; i < 3; i++)
        begin
            u[i]  = e_neg_reg[i] ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
            dt[i] = {r_reg[i], nb_reg[i][30]};
            fp_adj[i] = fp_reg[i][67] ? fp_reg[i] + 68'(ONE_Q30 - 32'd1) : fp_reg[i];
            fv[i] = 41'(3 * (fp_adj[i] >>> 30)) - 41'(o[i]);
            wide[i] = 201'(nacc_reg[i]) << k_reg;
            qt[i] = {qr_reg[i], xlo_reg[i][47]};
        end
    end

    // final saturation and sign
    logic        ng [3];
    logic [47:0] lim [3];
    logic [47:0] qv [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
            begin
                ng[i]  = (mneg == (!o[i][31] && o[i] != 32'sd0));
                lim[i] = ng[i] ? FIELD_NEG_LIM : FIELD_POS_LIM;
                qv[i]  = (mmag != 64'd0 && o[i] != 32'sd0) ? lim[i] : 48'd0;
            end
            else
            begin
                ng[i]  = mneg ^ fneg_reg[i];
                lim[i] = ng[i] ? FIELD_NEG_LIM : FIELD_POS_LIM;
                qv[i]  = (sat_reg[i] || qq_reg[i] > lim[i]) ? lim[i] : qq_reg[i];
            end
            res[i] = ng[i] ? 48'(-qv[i]) : qv[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (field.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (rd_valid)
                        state_reg <= rd_data.zero ? S_FIN : S_SUMSQ;
                end
                S_SUMSQ:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == SQRT_LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= S_DOT1;
                end
                S_DOT1: state_reg <= S_DOT2;
                S_DOT2: state_reg <= S_F1;
                S_F1:   state_reg <= S_F2;
                S_F2:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == MUL_LAST)
                        state_reg <= S_SHIFT;
                end
                S_SHIFT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_QDIV;
                end
                S_QDIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == QDIV_LAST)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                    e_mag_reg[i] <= rd_data.e_mag[i];
                e_neg_reg <= rd_data.e_neg;
                k_reg     <= rd_data.k;
                rng_reg   <= rd_data.in_range;
                zero_reg  <= rd_data.zero;
            end
            S_SUMSQ:
            begin
                x_reg <= 62'(e_mag_reg[0]) * 62'(e_mag_reg[0])
                       + 62'(e_mag_reg[1]) * 62'(e_mag_reg[1])
                       + 62'(e_mag_reg[2]) * 62'(e_mag_reg[2]);
                rem_reg  <= '0;
                root_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    r_reg[i]  <= 31'(e_mag_reg[i] >> 1);
                    nb_reg[i] <= {e_mag_reg[i][0], 30'd0};
                    q_reg[i]  <= '0;
                end
            end
            S_SQRT:
            begin
                x_reg <= {x_reg[59:0], 2'b00};
                if (rem2 >= trial)
                begin
                    rem_reg  <= rem2 - trial;
                    root_reg <= {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem2;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
            end
            S_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nb_reg[i] <= {nb_reg[i][29:0], 1'b0};
                    if (dt[i] >= {1'b0, root_reg})
                    begin
                        r_reg[i] <= 31'(dt[i] - {1'b0, root_reg});
                        q_reg[i] <= {q_reg[i][29:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[i] <= dt[i][30:0];
                        q_reg[i] <= {q_reg[i][29:0], 1'b0};
                    end
                end
            end
            S_DOT1:
            begin
                for (int i = 0; i < 3; i++)
                    prod_reg[i] <= o[i] * u[i];
                rn2_reg <= 62'(root_reg) * 62'(root_reg);
            end
            S_DOT2:
            begin
                dot_reg <= 36'(s_adj >>> 30);
            end
            S_F1:
            begin
                for (int i = 0; i < 3; i++)
                    fp_reg[i] <= dot_reg * u[i];
            end
            S_F2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fneg_reg[i] <= fv[i][40];
                    fmag_reg[i] <= fv[i][40] ? 40'(-fv[i]) : 40'(fv[i]);
                    nacc_reg[i] <= '0;
                end
                dacc_reg <= '0;
                rnsh_reg <= {9'd0, root_reg};
            end
            S_MUL:
            begin
                // one byte of the multiplier per cycle, most significant first
                for (int i = 0; i < 3; i++)
                begin
                    nacc_reg[i] <= (nacc_reg[i] << 8) + 104'(mmag) * 104'(fmag_reg[i][39:32]);
                    fmag_reg[i] <= {fmag_reg[i][31:0], 8'd0};
                end
                dacc_reg <= (dacc_reg << 8) + 102'(rn2_reg) * 102'(rnsh_reg[39:32]);
                rnsh_reg <= {rnsh_reg[31:0], 8'd0};
            end
            S_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sat_reg[i] <= (wide[i][200:48] >= 153'(dcube));
                    qr_reg[i]  <= wide[i][140:48];
                    xlo_reg[i] <= wide[i][47:0];
                    qq_reg[i]  <= '0;
                end
            end
            S_QDIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    xlo_reg[i] <= {xlo_reg[i][46:0], 1'b0};
                    if (qt[i] >= {1'b0, dcube})
                    begin
                        qr_reg[i] <= 93'(qt[i] - {1'b0, dcube});
                        qq_reg[i] <= {qq_reg[i][46:0], 1'b1};
                    end
                    else
                    begin
                        qr_reg[i] <= qt[i][92:0];
                        qq_reg[i] <= {qq_reg[i][46:0], 1'b0};
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    fx_reg      <= res[0];
                    fy_reg      <= res[1];
                    fz_reg      <= res[2];
                    out_rng_reg <= rng_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign field.valid    = out_valid_reg;
    assign field.field_x  = fx_reg;
    assign field.field_y  = fy_reg;
    assign field.field_z  = fz_reg;
    assign field.in_range = out_rng_reg;

endmodule

// ----- design/dipole_magnetic_field.sv -----
// Top level of the offset dipole magnetic field evaluator.
//
//   channel | role   | payload
//   pos     | sink   | pos_x, pos_y, pos_z (signed 32, 1/256 km)
//   field   | source | field_x, field_y, field_z (signed 48, nT Q32.16), in_range
//   cfg     | sink   | index (4), wdata (64); indexes 8..15 are dropped
//
// The front end takes one request per cycle while the queue has room, into a queue of QUEUE_DEPTH entries.
// The back end takes one request at a time; its work is paced by the bit-serial square root,
// the unit-vector divide and the final field divide (a request at the dipole centre skips them);
// the output register holds a result while the back end starts on the next request.
// Reset: no requests in flight, registers at their documented defaults.
module dipole_magnetic_field #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    dmf_pos_if.sink     pos,
    dmf_field_if.source field,
    dmf_cfg_if.sink     cfg
);
    import dmf_pkg::*;

    cfg_t  cfg_reg;
    task_t push_data;
    logic  push_valid;
    logic  push_ready;
    task_t pop_data;
    logic  pop_valid;
    logic  pop_ready;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dipole_x   <= '0;
            cfg_reg.dipole_y   <= '0;
            cfg_reg.orient_x   <= '0;
            cfg_reg.orient_y   <= '0;
            cfg_reg.orient_z   <= $signed(ONE_Q30);
            cfg_reg.moment     <= '0;
            cfg_reg.min_radius <= '0;
            cfg_reg.max_radius <= '1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIPOLE_X: cfg_reg.dipole_x   <= cfg.wdata[31:0];
                REG_DIPOLE_Y: cfg_reg.dipole_y   <= cfg.wdata[31:0];
                REG_ORIENT_X: cfg_reg.orient_x   <= cfg.wdata[31:0];
                REG_ORIENT_Y: cfg_reg.orient_y   <= cfg.wdata[31:0];
                REG_ORIENT_Z: cfg_reg.orient_z   <= cfg.wdata[31:0];
                REG_MOMENT:   cfg_reg.moment     <= cfg.wdata;
                REG_MIN_RAD:  cfg_reg.min_radius <= cfg.wdata[30:0];
                REG_MAX_RAD:  cfg_reg.max_radius <= cfg.wdata[30:0];
                default:
                begin
                end
            endcase
        end
    end

    dmf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pos        (pos),
        .cfg        (cfg_reg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dmf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (push_data),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .rd_data  (pop_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready)
    );

    dmf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .rd_data  (pop_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .field    (field)
    );

endmodule

// ----- dv/tb_dipole_magnetic_field.sv -----
// Testbench for the offset dipole field evaluator: directed and random positions vs. predictor.
`timescale 1ns / 1ps

module tb_dipole_magnetic_field;
    import dmf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
    localparam int  DRAIN_CYCLES = 130;
    localparam int  CYCLE_LIMIT  = 1500000;
    localparam longint Q30 = longint'(ONE_Q30);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } pos_t;

    typedef struct packed {
        logic [47:0] field_x;
        logic [47:0] field_y;
        logic [47:0] field_z;
        logic        in_range;
    } field_t;

    logic clk = 1'b0;
    logic rst_n;

    dmf_pos_if   pos_if();
    dmf_field_if field_if();
    dmf_cfg_if   cfg_if();

    dipole_magnetic_field u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pos   (pos_if),
        .field (field_if),
        .cfg   (cfg_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor copy of the register file
    longint     dip_x, dip_y, ax_x, ax_y, ax_z;
    bit [63:0]  moment_r;
    bit [30:0]  rmin, rmax;

    pos_t       pos_pending[$];
    field_t     field_expected[$];
    int         fail_cnt = 0;
    int         cycle_cnt = 0;
    bit         pos_taken = 1'b0;
    int         src_gap = 0;
    int         src_burst = 0;
    int         sink_stall = 0;
    int         sink_burst = 0;

    function automatic bit [63:0] isqrt64(input bit [63:0] x);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic field_t field_predict(input pos_t p);
        longint     d[3], e[3], u[3], o[3], f[3], pv[3];
        longint     dotp;
        bit [63:0]  rr, a, mx, r2n, rn, mmag, fm, mn, mxr;
        bit [255:0] num, den, q, lim;
        bit [47:0]  val[3];
        bit         mneg, neg;
        int         rs, ls, k;
        field_t     r;
        pv[0] = p.pos_x; pv[1] = p.pos_y; pv[2] = p.pos_z;
        o[0] = ax_x; o[1] = ax_y; o[2] = ax_z;
        rr = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = (pv[i] < 0) ? -pv[i] : pv[i];
            rr = rr + a * a;    // 64-bit sum like the hardware rr
        end
        mn = rmin;
        mxr = rmax;
        r.in_range = (rr > mn * mn) && (rr < mxr * mxr);
        d[0] = pv[0] - dip_x;
        d[1] = pv[1] - dip_y;
        d[2] = pv[2];
        mneg = moment_r[63];
        mmag = mneg ? (~moment_r + 64'd1) : moment_r;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = (d[i] < 0) ? -d[i] : d[i];
            if (a > mx) mx = a;
        end
        if (mx == 0)
        begin
            // query on the dipole centre: saturate with the sign of m*o
            for (int i = 0; i < 3; i++)
            begin
                neg = (mneg == (o[i] > 0));
                q = 0;
                if (mmag != 0 && o[i] != 0)
                    q = neg ? 256'(FIELD_NEG_LIM) : 256'(FIELD_POS_LIM);
                val[i] = neg ? (48'd0 - q[47:0]) : q[47:0];
            end
        end
        else
        begin
            rs = 0;
            ls = 0;
            while ((mx >> rs) >= (64'd1 << 30)) rs++;
            while ((mx << ls) < (64'd1 << 29)) ls++;
            k = 10 + 3 * ls - 3 * rs;
            r2n = 0;
            for (int i = 0; i < 3; i++)
            begin
                a = (((d[i] < 0) ? -d[i] : d[i]) >> rs) << ls;
                e[i] = (d[i] < 0) ? -longint'(a) : longint'(a);
                r2n = r2n + a * a;
            end
            rn = isqrt64(r2n);
            for (int i = 0; i < 3; i++) u[i] = (e[i] * Q30) / longint'(rn);
            dotp = (o[0] * u[0] + o[1] * u[1] + o[2] * u[2]) / Q30;
            for (int i = 0; i < 3; i++) f[i] = 3 * ((dotp * u[i]) / Q30) - o[i];
            den = 256'(rn);
            den = den * den * 256'(rn);
            for (int i = 0; i < 3; i++)
            begin
                neg = mneg != (f[i] < 0);
                fm = (f[i] < 0) ? -f[i] : f[i];
                num = (256'(mmag) * 256'(fm)) << k;
                q = num / den;
                lim = neg ? 256'(FIELD_NEG_LIM) : 256'(FIELD_POS_LIM);
                if (q > lim) q = lim;
                val[i] = neg ? (48'd0 - q[47:0]) : q[47:0];
            end
        end
        r.field_x = val[0];
        r.field_y = val[1];
        r.field_z = val[2];
        return r;
    endfunction

    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) burst = $urandom_range(20, 200);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // sampling side: requests, results, register writes, timeout
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            pos_taken <= pos_if.valid && pos_if.ready;
            if (pos_if.valid && pos_if.ready)
                field_expected.push_back(field_predict({pos_if.pos_x, pos_if.pos_y,
                                                         pos_if.pos_z}));
            if (field_if.valid && field_if.ready)
            begin
                if (field_expected.size() == 0)
                begin
                    $display("%0t: unexpected result x=%h y=%h z=%h r=%b", $realtime,
                             field_if.field_x, field_if.field_y, field_if.field_z,
                             field_if.in_range);
                    fail_cnt++;
                end
                else
                begin : cmp
                    field_t ex;
                    ex = field_expected.pop_front();
                    if (ex.field_x !== field_if.field_x)
                    begin
                        $display("%0t: field_x exp %h got %h", $realtime, ex.field_x,
                                 field_if.field_x);
                        fail_cnt++;
                    end
                    if (ex.field_y !== field_if.field_y)
                    begin
                        $display("%0t: field_y exp %h got %h", $realtime, ex.field_y,
                                 field_if.field_y);
                        fail_cnt++;
                    end
                    if (ex.field_z !== field_if.field_z)
                    begin
                        $display("%0t: field_z exp %h got %h", $realtime, ex.field_z,
                                 field_if.field_z);
                        fail_cnt++;
                    end
                    if (ex.in_range !== field_if.in_range)
                    begin
                        $display("%0t: in_range exp %b got %b", $realtime, ex.in_range,
                                 field_if.in_range);
                        fail_cnt++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
            begin
                case (cfg_if.index)
                    REG_DIPOLE_X: dip_x = longint'($signed(cfg_if.wdata[31:0]));
                    REG_DIPOLE_Y: dip_y = longint'($signed(cfg_if.wdata[31:0]));
                    REG_ORIENT_X: ax_x = longint'($signed(cfg_if.wdata[31:0]));
                    REG_ORIENT_Y: ax_y = longint'($signed(cfg_if.wdata[31:0]));
                    REG_ORIENT_Z: ax_z = longint'($signed(cfg_if.wdata[31:0]));
                    REG_MOMENT:   moment_r = cfg_if.wdata;
                    REG_MIN_RAD:  rmin = cfg_if.wdata[30:0];
                    REG_MAX_RAD:  rmax = cfg_if.wdata[30:0];
                    default: ;
                endcase
            end
        end
    end

    // request driver
    always @(negedge clk)
    begin : drive
        logic v;
        pos_t item;
        if (rst_n && (!pos_if.valid || pos_taken))
        begin
            v = 1'b0;
            item = {pos_if.pos_x, pos_if.pos_y, pos_if.pos_z};
            if (src_gap > 0)
                src_gap--;
            else if (pos_pending.size() > 0)
            begin
                item = pos_pending.pop_front();
                v = 1'b1;
                src_gap = pick_gap(src_burst);
            end
            pos_if.valid <= v;
            pos_if.pos_x <= item.pos_x;
            pos_if.pos_y <= item.pos_y;
            pos_if.pos_z <= item.pos_z;
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_stall > 0)
            begin
                sink_stall--;
                field_if.ready <= 1'b0;
            end
            else
            begin
                field_if.ready <= 1'b1;
                sink_stall = pick_gap(sink_burst);
            end
        end
    end

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_if.ready) break;
        end
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain_wait();
        forever
        begin
            @(posedge clk);
            if (pos_pending.size() == 0 && !pos_if.valid && field_expected.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup(input longint dx, input longint dy, input longint ox,
                              input longint oy, input longint oz, input logic [63:0] m,
                              input logic [30:0] lo, input logic [30:0] hi);
        reg_write(REG_DIPOLE_X, 64'(dx));
        reg_write(REG_DIPOLE_Y, 64'(dy));
        reg_write(REG_ORIENT_X, 64'(ox));
        reg_write(REG_ORIENT_Y, 64'(oy));
        reg_write(REG_ORIENT_Z, 64'(oz));
        reg_write(REG_MOMENT, m);
        reg_write(REG_MIN_RAD, 64'(lo));
        reg_write(REG_MAX_RAD, 64'(hi));
    endtask

    task automatic push_pos(input longint x, input longint y, input longint z);
        pos_t p;
        p.pos_x = x[31:0];
        p.pos_y = y[31:0];
        p.pos_z = z[31:0];
        pos_pending.push_back(p);
    endtask

    // edge positions: at and next to the current dipole centre, the origin and the extremes
    task automatic directed_set();
        push_pos(dip_x, dip_y, 0);
        push_pos(0, 0, 0);
        push_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_pos(-2147483648, -2147483648, -2147483648);
        push_pos(32'h7FFF_FFFF, -2147483648, 0);
        push_pos(dip_x + 1, dip_y, 0);
        push_pos(dip_x, dip_y, -1);
        push_pos(dip_x, dip_y + 3, 1000000);
    endtask

    function automatic longint rand_axis();
        return longint'($urandom_range(0, 32'h8000_0000)) - Q30;
    endfunction

    task automatic random_setup();
        logic [63:0] m;
        logic [30:0] lo;
        case ($urandom_range(0, 2))
            0: m = {$urandom, $urandom};
            1: m = 64'($urandom_range(0, 32'hFFFF_FFFF)) << $urandom_range(0, 30);
            default: m = -(64'($urandom) << $urandom_range(0, 31));
        endcase
        lo = 31'($urandom_range(0, 32'h03FF_FFFF));
        load_setup(longint'($signed($urandom)), longint'($signed($urandom)),
                   rand_axis(), rand_axis(), rand_axis(), m, lo,
                   31'(lo + $urandom_range(0, 32'h3FFF_FFFF)));
    endtask

    task automatic random_items(input int n);
        longint sc;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    push_pos($signed($urandom), $signed($urandom), $signed($urandom));
                3, 4:
                    push_pos(dip_x + $urandom_range(0, 8191) - 4096,
                             dip_y + $urandom_range(0, 8191) - 4096,
                             longint'($urandom_range(0, 8191)) - 4096);
                5:
                    push_pos(dip_x, dip_y, ($urandom_range(0, 3) == 0) ? 0 :
                             longint'($urandom_range(0, 15)) - 8);
                default:
                begin
                    sc = longint'(1) << $urandom_range(8, 30);
                    push_pos(dip_x + longint'($urandom_range(0, 32'(2 * sc))) - sc,
                             dip_y + longint'($urandom_range(0, 32'(2 * sc))) - sc,
                             longint'($urandom_range(0, 32'(2 * sc))) - sc);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        pos_if.valid = 1'b0;
        pos_if.pos_x = '0;
        pos_if.pos_y = '0;
        pos_if.pos_z = '0;
        field_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.wdata = '0;
        dip_x = 0; dip_y = 0;
        ax_x = 0; ax_y = 0; ax_z = Q30;
        moment_r = 0;
        rmin = 0;
        rmax = 31'h7FFF_FFFF;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults out of reset: zero moment
        push_pos(100, 200, 300);
        push_pos(0, 0, 0);
        drain_wait();

        load_setup(1000, -2000, 0, 0, Q30, 64'd8_000_000_000_000_000, 31'd256000,
                   31'd81548800);
        directed_set();
        drain_wait();

        // extreme registers, non-normalized axis, inverted radius band
        load_setup(32'h7FFF_FFFF, -2147483648, -Q30, Q30, -Q30, 64'h8000_0000_0000_0000,
                   31'h7FFF_FFFF, 31'd0);
        reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        directed_set();
        drain_wait();

        load_setup(0, 0, Q30, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 31'd0, 31'h7FFF_FFFF);
        directed_set();
        drain_wait();

        for (int ph = 0; ph < 5; ph++)
        begin
            random_setup();
            random_items(250);
            drain_wait();
        end

        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/dmf_pkg.sv
design/dmf_ifs.sv
design/dmf_front.sv
design/dmf_fifo.sv
design/dmf_back.sv
design/dipole_magnetic_field.sv
dv/tb_dipole_magnetic_field.sv
